@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/alf_pkg.sv @@
// Shared types for the aspect-fit letterbox pipeline.
package alf_pkg;

	// Which side of the frame the fitted rectangle fills.
	typedef enum logic [1:0] {
		MODE_FILL_W,
		MODE_FILL_H,
		MODE_PASS
	} mode_t;

endpackage

@@ sv/alf_div_cell.sv @@
// One restoring-division cell: retires one quotient bit per stage.
module alf_div_cell #(
	parameter int CB     = 16,
	parameter int SIDE_W = 66
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              in_valid,
	input  logic [CB-1:0]     in_rem,
	input  logic [CB-1:0]     in_num,
	input  logic [CB-1:0]     in_quot,
	input  logic [CB-1:0]     in_div,
	input  logic [SIDE_W-1:0] in_side,
	output logic              valid_q,
	output logic [CB-1:0]     rem_q,
	output logic [CB-1:0]     num_q,
	output logic [CB-1:0]     quot_q,
	output logic [CB-1:0]     div_q,
	output logic [SIDE_W-1:0] side_q
);

	logic [CB:0]   trial;
	logic [CB:0]   diff;
	logic          ge;
	logic [CB-1:0] rem_nxt;

	// Partial remainder stays below the divisor, so CB bits hold it.
	assign trial   = {in_rem, in_num[CB-1]};
	assign diff    = trial - {1'b0, in_div};
	assign ge      = trial >= {1'b0, in_div};
	assign rem_nxt = ge ? diff[CB-1:0] : trial[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= rem_nxt;
			num_q  <= {in_num[CB-2:0], 1'b0};
			quot_q <= {in_quot[CB-2:0], ge};
			div_q  <= in_div;
			side_q <= in_side;
		end
	end

endmodule

@@ sv/alf_place.sv @@
// Output stage: centers the fitted rectangle, saturates, holds the result.
module alf_place #(
	parameter int CB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [CB-1:0]        quot,
	input  alf_pkg::mode_t       mode,
	input  logic [CB-1:0]        fx,
	input  logic [CB-1:0]        fy,
	input  logic [CB-1:0]        fw,
	input  logic [CB-1:0]        fh,
	input  logic                 fit_stall,
	output logic                 load,
	output logic                 fit_valid,
	output logic signed [CB-1:0] fit_x,
	output logic signed [CB-1:0] fit_y,
	output logic [CB-1:0]        fit_w,
	output logic [CB-1:0]        fit_h,
	output logic                 passed_through
);

	logic          valid_q;
	logic [CB-1:0] x_q;
	logic [CB-1:0] y_q;
	logic [CB-1:0] w_q;
	logic [CB-1:0] h_q;
	logic          pt_q;

	logic [CB-1:0] x_nxt;
	logic [CB-1:0] y_nxt;
	logic [CB-1:0] w_nxt;
	logic [CB-1:0] h_nxt;
	logic          pt_nxt;

	// base + slack/2, clipped at the top of the signed range (it only grows)
	function automatic logic [CB-1:0] centre(logic [CB-1:0] base, logic [CB-1:0] slack);
		logic signed [CB:0] sum;
		sum = $signed({base[CB-1], base}) + $signed({2'b00, slack[CB-1:1]});
		return (!sum[CB] && sum[CB-1]) ? {1'b0, {(CB-1){1'b1}}} : sum[CB-1:0];
	endfunction

	always_comb begin
		x_nxt  = fx;
		y_nxt  = fy;
		w_nxt  = fw;
		h_nxt  = fh;
		pt_nxt = 1'b0;
		case (mode)
			alf_pkg::MODE_FILL_W: begin
				h_nxt = quot;
				y_nxt = centre(fy, fh - quot);
			end
			alf_pkg::MODE_FILL_H: begin
				w_nxt = quot;
				x_nxt = centre(fx, fw - quot);
			end
			alf_pkg::MODE_PASS: begin
				pt_nxt = 1'b1;
			end
			default: begin
				pt_nxt = 1'b1;
			end
		endcase
	end

	assign load = !valid_q || !fit_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q  <= x_nxt;
			y_q  <= y_nxt;
			w_q  <= w_nxt;
			h_q  <= h_nxt;
			pt_q <= pt_nxt;
		end
	end

	assign fit_valid      = valid_q;
	assign fit_x          = $signed(x_q);
	assign fit_y          = $signed(y_q);
	assign fit_w          = w_q;
	assign fit_h          = h_q;
	assign passed_through = pt_q;

endmodule

@@ sv/aspect_fit_letterbox_core.sv @@
// Aspect-fit letterbox top level: cross products, division cell chain, placement.
//
// Source channel: src_valid / src_stall carry one transaction per item
// (inner_w, inner_h, frame_x, frame_y, frame_w, frame_h). Result channel:
// fit_valid / fit_stall carry fit_x, fit_y, fit_w, fit_h, passed_through.
// A transaction completes on a rising edge with valid high and stall low.
// Every item yields exactly one result, in order.
// The pipeline registers, in order: the two cross products, the compare and
// operand select, a chain of COORD_BITS division cells with one quotient
// bit each, and the output register. Throughput is one item per cycle
// while fit_stall is low; each cell retires one quotient bit of a different
// item every cycle.
// When fit_stall is high the result holds in the output register; stages
// behind it keep moving until they reach an occupied stage, so bubbles are
// squeezed out before src_stall rises.
// arst_n clears every stage valid flag; the pipeline comes out empty.
module aspect_fit_letterbox_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         src_valid,
	output logic                         src_stall,
	input  logic [COORD_BITS-1:0]        inner_w,
	input  logic [COORD_BITS-1:0]        inner_h,
	input  logic signed [COORD_BITS-1:0] frame_x,
	input  logic signed [COORD_BITS-1:0] frame_y,
	input  logic [COORD_BITS-1:0]        frame_w,
	input  logic [COORD_BITS-1:0]        frame_h,
	output logic                         fit_valid,
	input  logic                         fit_stall,
	output logic signed [COORD_BITS-1:0] fit_x,
	output logic signed [COORD_BITS-1:0] fit_y,
	output logic [COORD_BITS-1:0]        fit_w,
	output logic [COORD_BITS-1:0]        fit_h,
	output logic                         passed_through
);

	localparam int CB     = COORD_BITS;
	localparam int MODE_W = $bits(alf_pkg::mode_t);
	localparam int SIDE_W = 4 * CB + MODE_W;

	// stage 1: cross products
	logic            v_s1;
	logic            load_s1;
	logic [2*CB-1:0] pa_s1;   // inner_w * frame_h
	logic [2*CB-1:0] pb_s1;   // frame_w * inner_h
	logic [CB-1:0]   iw_s1;
	logic [CB-1:0]   ih_s1;
	logic [CB-1:0]   fx_s1;
	logic [CB-1:0]   fy_s1;
	logic [CB-1:0]   fw_s1;
	logic [CB-1:0]   fh_s1;
	logic            zero_s1;

	// stage 2: dividend split into first remainder and bits still to shift in
	logic            v_s2;
	logic            load_s2;
	logic [CB-1:0]   rem_s2;
	logic [CB-1:0]   num_s2;
	logic [CB-1:0]   div_s2;
	logic [SIDE_W-1:0] side_s2;

	alf_pkg::mode_t  mode_c;
	logic [2*CB-1:0] num_c;
	logic [CB-1:0]   div_c;

	// division chain
	logic              cell_v    [CB];
	logic              cell_load [CB];
	logic [CB-1:0]     cell_rem  [CB];
	logic [CB-1:0]     cell_num  [CB];
	logic [CB-1:0]     cell_quot [CB];
	logic [CB-1:0]     cell_div  [CB];
	logic [SIDE_W-1:0] cell_side [CB];

	logic              place_load;
	logic [SIDE_W-1:0] side_last;

	assign load_s1   = !v_s1 || load_s2;
	assign load_s2   = !v_s2 || cell_load[0];
	assign src_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= src_valid;
			end
			if (load_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pa_s1   <= (2*CB)'(inner_w) * (2*CB)'(frame_h);
			pb_s1   <= (2*CB)'(frame_w) * (2*CB)'(inner_h);
			iw_s1   <= inner_w;
			ih_s1   <= inner_h;
			fx_s1   <= frame_x;
			fy_s1   <= frame_y;
			fw_s1   <= frame_w;
			fh_s1   <= frame_h;
			zero_s1 <= (inner_w == '0) || (inner_h == '0) || (frame_w == '0)
				|| (frame_h == '0);
		end
	end

	// Equal ratios fill the height. frame_h * inner_w is the same product as pa.
	always_comb begin
		if (zero_s1) begin
			mode_c = alf_pkg::MODE_PASS;
		end else if (pa_s1 > pb_s1) begin
			mode_c = alf_pkg::MODE_FILL_W;
		end else begin
			mode_c = alf_pkg::MODE_FILL_H;
		end
		if (mode_c == alf_pkg::MODE_FILL_W) begin
			num_c = pb_s1;
			div_c = iw_s1;
		end else begin
			num_c = pa_s1;
			div_c = ih_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			rem_s2  <= num_c[2*CB-1:CB];
			num_s2  <= num_c[CB-1:0];
			div_s2  <= div_c;
			side_s2 <= {mode_c, fx_s1, fy_s1, fw_s1, fh_s1};
		end
	end

	for (genvar k = 0; k < CB; k++) begin : g_cell
		if (k == 0) begin : g_head
			alf_div_cell #(.CB(CB), .SIDE_W(SIDE_W)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.load    (cell_load[k]),
				.in_valid(v_s2),
				.in_rem  (rem_s2),
				.in_num  (num_s2),
				.in_quot ('0),
				.in_div  (div_s2),
				.in_side (side_s2),
				.valid_q (cell_v[k]),
				.rem_q   (cell_rem[k]),
				.num_q   (cell_num[k]),
				.quot_q  (cell_quot[k]),
				.div_q   (cell_div[k]),
				.side_q  (cell_side[k])
			);
		end else begin : g_body
			alf_div_cell #(.CB(CB), .SIDE_W(SIDE_W)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.load    (cell_load[k]),
				.in_valid(cell_v[k-1]),
				.in_rem  (cell_rem[k-1]),
				.in_num  (cell_num[k-1]),
				.in_quot (cell_quot[k-1]),
				.in_div  (cell_div[k-1]),
				.in_side (cell_side[k-1]),
				.valid_q (cell_v[k]),
				.rem_q   (cell_rem[k]),
				.num_q   (cell_num[k]),
				.quot_q  (cell_quot[k]),
				.div_q   (cell_div[k]),
				.side_q  (cell_side[k])
			);
		end
		if (k == CB - 1) begin : g_tail_load
			assign cell_load[k] = !cell_v[k] || place_load;
		end else begin : g_mid_load
			assign cell_load[k] = !cell_v[k] || cell_load[k+1];
		end
	end

	assign side_last = cell_side[CB-1];

	alf_place #(.CB(CB)) u_place (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (cell_v[CB-1]),
		.quot          (cell_quot[CB-1]),
		.mode          (alf_pkg::mode_t'(side_last[SIDE_W-1 -: MODE_W])),
		.fx            (side_last[4*CB-1 -: CB]),
		.fy            (side_last[3*CB-1 -: CB]),
		.fw            (side_last[2*CB-1 -: CB]),
		.fh            (side_last[CB-1:0]),
		.fit_stall     (fit_stall),
		.load          (place_load),
		.fit_valid     (fit_valid),
		.fit_x         (fit_x),
		.fit_y         (fit_y),
		.fit_w         (fit_w),
		.fit_h         (fit_h),
		.passed_through(passed_through)
	);

endmodule

@@ sv/alf_checker.sv @@
// Port-level checker for the aspect-fit letterbox core, bound to the top level.
`include "assert_macros.svh"

module alf_checker #(
	parameter int COORD_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         src_valid,
	input logic                         src_stall,
	input logic                         fit_valid,
	input logic                         fit_stall,
	input logic signed [COORD_BITS-1:0] fit_x,
	input logic signed [COORD_BITS-1:0] fit_y,
	input logic [COORD_BITS-1:0]        fit_w,
	input logic [COORD_BITS-1:0]        fit_h,
	input logic                         passed_through
);

	localparam int DEPTH = COORD_BITS + 3;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic             src_take;
	logic             fit_take;
	logic [CNT_W-1:0] inflight_q;

	assign src_take = src_valid && !src_stall;
	assign fit_take = fit_valid && !fit_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({src_take, fit_take})
				2'b10:   inflight_q <= inflight_q + CNT_W'(1);
				2'b01:   inflight_q <= inflight_q - CNT_W'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	`ASSERT_CLK(a_hold_on_stall, clk, arst_n, fit_valid && fit_stall |=> fit_valid && $stable({fit_x, fit_y, fit_w, fit_h, passed_through}), "result changed while stalled")
	`ASSERT_CLK(a_no_phantom, clk, arst_n, fit_valid |-> inflight_q != '0, "result without a pending transaction")
	`ASSERT_CLK(a_depth, clk, arst_n, inflight_q <= CNT_W'(DEPTH), "more transactions in flight than pipeline stages")
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !fit_valid, "result valid during reset")

endmodule

bind aspect_fit_letterbox_core alf_checker #(.COORD_BITS(COORD_BITS)) u_alf_checker (.*);
